// ===== rtl/core/pdp11_instruction_predecoder_defines.svh =====
// Assertion macros shared by the predecoder RTL.
`ifndef PDP11_INSTRUCTION_PREDECODER_DEFINES_SVH
`define PDP11_INSTRUCTION_PREDECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge, switched off while reset is held.
`define PD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PD_ASSERT(label, prop, msg)
`define PD_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/core/pdp11_pd_pkg.sv =====
// Mnemonic numbers, operand format codes and result type of the PDP-11 predecoder.
package pdp11_pd_pkg;

    localparam int WORD_W = 16;

    // Operand format codes.
    localparam logic [3:0] FMT_NONE   = 4'd0;
    localparam logic [3:0] FMT_BRANCH = 4'd1;
    localparam logic [3:0] FMT_FLOAT  = 4'd2;
    localparam logic [3:0] FMT_TWO    = 4'd3;
    localparam logic [3:0] FMT_ONE    = 4'd4;
    localparam logic [3:0] FMT_REGGEN = 4'd5;
    localparam logic [3:0] FMT_SOB    = 4'd6;
    localparam logic [3:0] FMT_TRAP   = 4'd7;
    localparam logic [3:0] FMT_MARK   = 4'd8;
    localparam logic [3:0] FMT_RAW    = 4'd9;

    // First mnemonic number of each group, in dense table order.
    localparam logic [6:0] ID_MOV     = 7'd0;
    localparam logic [6:0] ID_MOVB    = 7'd6;
    localparam logic [6:0] ID_JMP     = 7'd12;
    localparam logic [6:0] ID_SWAB    = 7'd13;
    localparam logic [6:0] ID_BR      = 7'd14;
    localparam logic [6:0] ID_JSR     = 7'd21;
    localparam logic [6:0] ID_CLR     = 7'd22;
    localparam logic [6:0] ID_MARK    = 7'd34;
    localparam logic [6:0] ID_MFPI    = 7'd35;
    localparam logic [6:0] ID_HALT    = 7'd38;
    localparam logic [6:0] ID_RTS     = 7'd45;
    localparam logic [6:0] ID_NOP     = 7'd46;
    localparam logic [6:0] ID_MUL     = 7'd78;
    localparam logic [6:0] ID_SOB     = 7'd83;
    localparam logic [6:0] ID_FADD    = 7'd84;
    localparam logic [6:0] ID_BPL     = 7'd88;
    localparam logic [6:0] ID_EMT     = 7'd96;
    localparam logic [6:0] ID_TRAP    = 7'd97;
    localparam logic [6:0] ID_CLRB    = 7'd98;
    localparam logic [6:0] ID_ILLEGAL = 7'd114;

    // Opcode field values that split the groups.
    localparam logic [5:0] IDX_HALT_GRP = 6'd0;
    localparam logic [5:0] IDX_JMP      = 6'd1;
    localparam logic [5:0] IDX_RTS_GRP  = 6'd2;
    localparam logic [5:0] IDX_SWAB     = 6'd3;
    localparam logic [5:0] IDX_BR_END   = 6'd32;
    localparam logic [5:0] IDX_JSR_END  = 6'd40;
    localparam logic [5:0] IDX_ONE_END  = 6'd52;
    localparam logic [5:0] IDX_MARK     = 6'd52;
    localparam logic [5:0] IDX_MFPI     = 6'd53;
    localparam logic [5:0] IDX_GRP_END  = 6'd56;
    localparam logic [5:0] IDX_EMT_END  = 6'd36;
    localparam logic [5:0] IDX_CLRB     = 6'd40;
    localparam logic [5:0] IDX_CLR      = 6'd40;
    localparam logic [2:0] SUB_FIS      = 3'd5;
    localparam logic [2:0] SUB_SOB      = 3'd7;
    localparam logic [2:0] SUB_EIS_END  = 3'd4;
    localparam logic [15:0] FIS_ZERO_MASK = 16'o000740;

    typedef struct packed {
        logic [6:0]        mnemonic_id;
        logic [3:0]        operand_format;
        logic [2:0]        reg_field;
        logic [5:0]        src_spec;
        logic [5:0]        dst_spec;
        logic [WORD_W-1:0] src_value;
        logic [WORD_W-1:0] dst_value;
        logic [WORD_W-1:0] branch_target;
        logic [7:0]        small_immediate;
        logic [1:0]        ext_words_used;
        logic [WORD_W-1:0] next_addr;
    } dec_result_t;

endpackage

// ===== rtl/core/pdp11_instruction_predecoder.sv =====
// PDP-11 instruction predecoder: input register, single-pass decode, result register.

// One instruction window (word, address and the two following words) is taken per beat
// and one decoded result is given per beat. A beat can be accepted in every clock cycle
// while the result register is not stalled; the result passes through the input register
// and then the result register, with the whole opcode decode and the operand address
// adders between them. While the result register is stalled the input register still
// takes one more beat. All address arithmetic wraps modulo 2^16.
`include "pdp11_instruction_predecoder_defines.svh"

module pdp11_instruction_predecoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_inst_word,
    input  logic [15:0] s_inst_addr,
    input  logic [15:0] s_ext_word_first,
    input  logic [15:0] s_ext_word_second,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_mnemonic_id,
    output logic [3:0]  m_operand_format,
    output logic [2:0]  m_reg_field,
    output logic [5:0]  m_src_spec,
    output logic [5:0]  m_dst_spec,
    output logic [15:0] m_src_value,
    output logic [15:0] m_dst_value,
    output logic [15:0] m_branch_target,
    output logic [7:0]  m_small_immediate,
    output logic [1:0]  m_ext_words_used,
    output logic [15:0] m_next_addr
);

    logic        stage_valid_reg;
    logic [15:0] inst_reg;
    logic [15:0] addr_reg;
    logic [15:0] ext1_reg;
    logic [15:0] ext2_reg;
    logic        out_valid_reg;
    pdp11_pd_pkg::dec_result_t res_reg;
    pdp11_pd_pkg::dec_result_t res_next;
    logic        out_advance;

    // An operand takes an extension word for immediate, absolute, index and deferred index.
    function automatic logic operand_needs(input logic [5:0] spec);
        operand_needs = ((spec[5:3] == 3'd2 || spec[5:3] == 3'd3) && spec[2:0] == 3'd7)
                        || spec[5:4] == 2'b11;
    endfunction

    function automatic logic operand_pc_rel(input logic [5:0] spec);
        operand_pc_rel = spec[5:4] == 2'b11 && spec[2:0] == 3'd7;
    endfunction

    assign out_advance = !out_valid_reg || m_ready;
    assign s_ready     = !stage_valid_reg || out_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            inst_reg <= s_inst_word;
            addr_reg <= s_inst_addr;
            ext1_reg <= s_ext_word_first;
            ext2_reg <= s_ext_word_second;
        end
    end

    always_comb begin
        logic [3:0]  top;
        logic [5:0]  idx;
        logic [5:0]  low;
        logic [2:0]  sub;
        logic [6:0]  id;
        logic [3:0]  fmt;
        logic [2:0]  rts_reg;
        logic        src_need;
        logic        dst_need;
        logic [15:0] pc0;
        logic [15:0] pc_src;
        logic [15:0] pc_dst;
        logic [15:0] dst_word;
        top     = inst_reg[15:12];
        idx     = inst_reg[11:6];
        low     = inst_reg[5:0];
        sub     = inst_reg[11:9];
        id      = pdp11_pd_pkg::ID_ILLEGAL;
        fmt     = pdp11_pd_pkg::FMT_RAW;
        rts_reg = 3'd0;

        case (top)
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
                id  = pdp11_pd_pkg::ID_MOV + 7'(top) - 7'd1;
                fmt = pdp11_pd_pkg::FMT_TWO;
            end
            4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14: begin
                id  = pdp11_pd_pkg::ID_MOVB + 7'(top) - 7'd9;
                fmt = pdp11_pd_pkg::FMT_TWO;
            end
            4'd0: begin
                if (idx == pdp11_pd_pkg::IDX_HALT_GRP) begin
                    if (low < 6'd7) begin
                        id  = pdp11_pd_pkg::ID_HALT + 7'(low[2:0]);
                        fmt = pdp11_pd_pkg::FMT_NONE;
                    end
                end else if (idx == pdp11_pd_pkg::IDX_JMP) begin
                    id  = pdp11_pd_pkg::ID_JMP;
                    fmt = pdp11_pd_pkg::FMT_ONE;
                end else if (idx == pdp11_pd_pkg::IDX_RTS_GRP) begin
                    if (low < 6'd8) begin
                        id      = pdp11_pd_pkg::ID_RTS;
                        fmt     = pdp11_pd_pkg::FMT_NONE;
                        rts_reg = inst_reg[2:0];
                    end else if (low[5]) begin
                        // Condition-code operators, one number per code.
                        id  = pdp11_pd_pkg::ID_NOP + 7'(low[4:0]);
                        fmt = pdp11_pd_pkg::FMT_NONE;
                    end
                end else if (idx == pdp11_pd_pkg::IDX_SWAB) begin
                    id  = pdp11_pd_pkg::ID_SWAB;
                    fmt = pdp11_pd_pkg::FMT_ONE;
                end else if (idx < pdp11_pd_pkg::IDX_BR_END) begin
                    id  = pdp11_pd_pkg::ID_BR + 7'(idx[4:2]) - 7'd1;
                    fmt = pdp11_pd_pkg::FMT_BRANCH;
                end else if (idx < pdp11_pd_pkg::IDX_JSR_END) begin
                    id  = pdp11_pd_pkg::ID_JSR;
                    fmt = pdp11_pd_pkg::FMT_REGGEN;
                end else if (idx < pdp11_pd_pkg::IDX_ONE_END) begin
                    id  = pdp11_pd_pkg::ID_CLR + 7'(idx - pdp11_pd_pkg::IDX_CLR);
                    fmt = pdp11_pd_pkg::FMT_ONE;
                end else if (idx == pdp11_pd_pkg::IDX_MARK) begin
                    id  = pdp11_pd_pkg::ID_MARK;
                    fmt = pdp11_pd_pkg::FMT_MARK;
                end else if (idx < pdp11_pd_pkg::IDX_GRP_END) begin
                    id  = pdp11_pd_pkg::ID_MFPI + 7'(idx - pdp11_pd_pkg::IDX_MFPI);
                    fmt = pdp11_pd_pkg::FMT_ONE;
                end
            end
            4'd7: begin
                if (sub <= pdp11_pd_pkg::SUB_EIS_END) begin
                    id  = pdp11_pd_pkg::ID_MUL + 7'(sub);
                    fmt = pdp11_pd_pkg::FMT_REGGEN;
                end else if (sub == pdp11_pd_pkg::SUB_FIS) begin
                    if ((inst_reg & pdp11_pd_pkg::FIS_ZERO_MASK) == 16'd0) begin
                        id  = pdp11_pd_pkg::ID_FADD + 7'(inst_reg[4:3]);
                        fmt = pdp11_pd_pkg::FMT_FLOAT;
                    end
                end else if (sub == pdp11_pd_pkg::SUB_SOB) begin
                    id  = pdp11_pd_pkg::ID_SOB;
                    fmt = pdp11_pd_pkg::FMT_SOB;
                end
            end
            4'd8: begin
                if (idx < pdp11_pd_pkg::IDX_BR_END) begin
                    id  = pdp11_pd_pkg::ID_BPL + 7'(idx[4:2]);
                    fmt = pdp11_pd_pkg::FMT_BRANCH;
                end else if (idx < pdp11_pd_pkg::IDX_EMT_END) begin
                    id  = pdp11_pd_pkg::ID_EMT;
                    fmt = pdp11_pd_pkg::FMT_TRAP;
                end else if (idx < pdp11_pd_pkg::IDX_JSR_END) begin
                    id  = pdp11_pd_pkg::ID_TRAP;
                    fmt = pdp11_pd_pkg::FMT_TRAP;
                end else if (idx < pdp11_pd_pkg::IDX_GRP_END) begin
                    id  = pdp11_pd_pkg::ID_CLRB + 7'(idx - pdp11_pd_pkg::IDX_CLRB);
                    fmt = pdp11_pd_pkg::FMT_ONE;
                end
            end
            default: begin
                id  = pdp11_pd_pkg::ID_ILLEGAL;
                fmt = pdp11_pd_pkg::FMT_RAW;
            end
        endcase

        // The first operand needing a word takes the first extension word.
        src_need = fmt == pdp11_pd_pkg::FMT_TWO && operand_needs(idx);
        dst_need = (fmt == pdp11_pd_pkg::FMT_TWO || fmt == pdp11_pd_pkg::FMT_ONE
                    || fmt == pdp11_pd_pkg::FMT_REGGEN) && operand_needs(low);
        pc0      = addr_reg + 16'd2;
        pc_src   = src_need ? pc0 + 16'd2 : pc0;
        pc_dst   = pc_src + 16'd2;
        dst_word = src_need ? ext2_reg : ext1_reg;

        res_next                 = '0;
        res_next.mnemonic_id     = id;
        res_next.operand_format  = fmt;
        res_next.ext_words_used  = {src_need && dst_need, src_need ^ dst_need};
        res_next.next_addr       = pc0 + {13'd0, res_next.ext_words_used, 1'b0};
        if (src_need) begin
            res_next.src_value = operand_pc_rel(idx) ? pc_src + ext1_reg : ext1_reg;
        end
        if (dst_need) begin
            res_next.dst_value = operand_pc_rel(low) ? pc_dst + dst_word : dst_word;
        end

        case (fmt)
            pdp11_pd_pkg::FMT_BRANCH: begin
                res_next.branch_target = pc0 + {{7{inst_reg[7]}}, inst_reg[7:0], 1'b0};
            end
            pdp11_pd_pkg::FMT_FLOAT: begin
                res_next.reg_field = inst_reg[2:0];
            end
            pdp11_pd_pkg::FMT_TWO: begin
                res_next.src_spec = idx;
                res_next.dst_spec = low;
            end
            pdp11_pd_pkg::FMT_ONE: begin
                res_next.dst_spec = low;
            end
            pdp11_pd_pkg::FMT_REGGEN: begin
                res_next.reg_field = inst_reg[8:6];
                res_next.dst_spec  = low;
            end
            pdp11_pd_pkg::FMT_SOB: begin
                res_next.reg_field     = inst_reg[8:6];
                res_next.branch_target = pc0 - {9'd0, low, 1'b0};
            end
            pdp11_pd_pkg::FMT_TRAP: begin
                res_next.small_immediate = inst_reg[7:0];
            end
            pdp11_pd_pkg::FMT_MARK: begin
                res_next.small_immediate = {2'd0, low};
            end
            pdp11_pd_pkg::FMT_NONE: begin
                res_next.reg_field = rts_reg;
            end
            default: begin
                res_next.reg_field = 3'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= stage_valid_reg;
        end
        if (out_advance && stage_valid_reg) begin
            res_reg <= res_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_mnemonic_id     = res_reg.mnemonic_id;
    assign m_operand_format  = res_reg.operand_format;
    assign m_reg_field       = res_reg.reg_field;
    assign m_src_spec        = res_reg.src_spec;
    assign m_dst_spec        = res_reg.dst_spec;
    assign m_src_value       = res_reg.src_value;
    assign m_dst_value       = res_reg.dst_value;
    assign m_branch_target   = res_reg.branch_target;
    assign m_small_immediate = res_reg.small_immediate;
    assign m_ext_words_used  = res_reg.ext_words_used;
    assign m_next_addr       = res_reg.next_addr;

    `PD_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_valid, "result valid after reset")
    `PD_ASSERT(a_stall_accept_empty, s_valid && s_ready && m_valid && !m_ready |-> !stage_valid_reg, "input register overwritten while result stalled")
    `PD_ASSERT(a_stage_moves_on, stage_valid_reg && (!m_valid || m_ready) |=> m_valid, "decoded beat lost between registers")
    `PD_ASSERT(a_words_in_range, m_valid |-> m_ext_words_used != 2'd3, "more than two extension words used")
    `PD_ASSERT(a_raw_is_bare, m_valid && m_operand_format == pdp11_pd_pkg::FMT_RAW |-> m_ext_words_used == 2'd0 && m_branch_target == 16'd0 && m_mnemonic_id == pdp11_pd_pkg::ID_ILLEGAL, "illegal word with operand fields")

endmodule

// ===== verif/pdp11_predecoder_checker.sv =====
// Checker for the PDP-11 predecoder: predicts each decoded result and compares it on the m_ side.
module pdp11_predecoder_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [15:0] s_inst_word,
    input  logic [15:0] s_inst_addr,
    input  logic [15:0] s_ext_word_first,
    input  logic [15:0] s_ext_word_second,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [6:0]  m_mnemonic_id,
    input  logic [3:0]  m_operand_format,
    input  logic [2:0]  m_reg_field,
    input  logic [5:0]  m_src_spec,
    input  logic [5:0]  m_dst_spec,
    input  logic [15:0] m_src_value,
    input  logic [15:0] m_dst_value,
    input  logic [15:0] m_branch_target,
    input  logic [7:0]  m_small_immediate,
    input  logic [1:0]  m_ext_words_used,
    input  logic [15:0] m_next_addr,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked
);

    // Top four bits of the instruction word that select the opcode groups.
    localparam logic [3:0] TOP_MISC       = 4'd0;
    localparam logic [3:0] TOP_WORD_FIRST = 4'd1;
    localparam logic [3:0] TOP_WORD_LAST  = 4'd6;
    localparam logic [3:0] TOP_EIS        = 4'd7;
    localparam logic [3:0] TOP_BYTE_GRP   = 4'd8;
    localparam logic [3:0] TOP_BYTE_FIRST = 4'd9;
    localparam logic [3:0] TOP_BYTE_LAST  = 4'd14;

    localparam logic [5:0] IDX_BR_FIRST = 6'd4;
    localparam logic [5:0] LOW_RTT      = 6'd6;
    localparam logic [5:0] LOW_RTS_END  = 6'd8;
    localparam logic [5:0] LOW_CC_FIRST = 6'd32;

    // Addressing modes and the register that make an operand take an extension word.
    localparam logic [2:0] MODE_AUTOINC     = 3'd2;
    localparam logic [2:0] MODE_AUTOINC_DEF = 3'd3;
    localparam logic [2:0] MODE_INDEX       = 3'd6;
    localparam logic [2:0] REG_PC           = 3'd7;

    localparam int REPORT_CAP = 200;

    pdp11_pd_pkg::dec_result_t expected_decodes[$];
    int                        reports;

    initial begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
        reports         = 0;
    end

    // Takes the next extension word for one operand where its mode needs one.
    function automatic void take_operand(input logic [5:0] spec, input logic [15:0] first_w,
                                         input logic [15:0] second_w,
                                         inout logic [15:0] pc, inout logic [1:0] used,
                                         output logic [15:0] value);
        logic [2:0]  rn;
        logic [2:0]  md;
        logic [15:0] w;
        rn = spec[2:0];
        md = spec[5:3];
        value = '0;
        if (((md == MODE_AUTOINC || md == MODE_AUTOINC_DEF) && rn == REG_PC) ||
            md >= MODE_INDEX) begin
            w = (used == 2'd0) ? first_w : second_w;
            used = used + 2'd1;
            pc = pc + 16'd2;
            // PC-relative operands give the effective address past the word.
            value = (md >= MODE_INDEX && rn == REG_PC) ? pc + w : w;
        end
    endfunction

    function automatic pdp11_pd_pkg::dec_result_t decode_window(
        input logic [15:0] iw, input logic [15:0] ia,
        input logic [15:0] fw, input logic [15:0] sw);
        pdp11_pd_pkg::dec_result_t r;
        logic [3:0]  top;
        logic [5:0]  idx;
        logic [5:0]  low;
        logic [2:0]  sub;
        logic [15:0] pc;
        logic [1:0]  used;
        logic [15:0] sval;
        logic [15:0] dval;
        top  = iw[15:12];
        idx  = iw[11:6];
        low  = iw[5:0];
        sub  = iw[11:9];
        pc   = ia + 16'd2;
        used = 2'd0;
        sval = '0;
        dval = '0;
        r = '0;
        r.mnemonic_id    = pdp11_pd_pkg::ID_ILLEGAL;
        r.operand_format = pdp11_pd_pkg::FMT_RAW;

        if (top >= TOP_WORD_FIRST && top <= TOP_WORD_LAST) begin
            r.mnemonic_id    = pdp11_pd_pkg::ID_MOV + 7'(top - TOP_WORD_FIRST);
            r.operand_format = pdp11_pd_pkg::FMT_TWO;
        end else if (top >= TOP_BYTE_FIRST && top <= TOP_BYTE_LAST) begin
            r.mnemonic_id    = pdp11_pd_pkg::ID_MOVB + 7'(top - TOP_BYTE_FIRST);
            r.operand_format = pdp11_pd_pkg::FMT_TWO;
        end else if (top == TOP_MISC) begin
            if (idx == pdp11_pd_pkg::IDX_HALT_GRP) begin
                if (low <= LOW_RTT) begin
                    r.mnemonic_id    = pdp11_pd_pkg::ID_HALT + 7'(low);
                    r.operand_format = pdp11_pd_pkg::FMT_NONE;
                end
            end else if (idx == pdp11_pd_pkg::IDX_JMP) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_JMP;
                r.operand_format = pdp11_pd_pkg::FMT_ONE;
            end else if (idx == pdp11_pd_pkg::IDX_RTS_GRP) begin
                if (low < LOW_RTS_END) begin
                    r.mnemonic_id    = pdp11_pd_pkg::ID_RTS;
                    r.operand_format = pdp11_pd_pkg::FMT_NONE;
                    r.reg_field      = iw[2:0];
                end else if (low >= LOW_CC_FIRST) begin
                    r.mnemonic_id    = pdp11_pd_pkg::ID_NOP + 7'(low - LOW_CC_FIRST);
                    r.operand_format = pdp11_pd_pkg::FMT_NONE;
                end
            end else if (idx == pdp11_pd_pkg::IDX_SWAB) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_SWAB;
                r.operand_format = pdp11_pd_pkg::FMT_ONE;
            end else if (idx < pdp11_pd_pkg::IDX_BR_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_BR + 7'((idx - IDX_BR_FIRST) >> 2);
                r.operand_format = pdp11_pd_pkg::FMT_BRANCH;
            end else if (idx < pdp11_pd_pkg::IDX_JSR_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_JSR;
                r.operand_format = pdp11_pd_pkg::FMT_REGGEN;
            end else if (idx < pdp11_pd_pkg::IDX_ONE_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_CLR + 7'(idx - pdp11_pd_pkg::IDX_CLR);
                r.operand_format = pdp11_pd_pkg::FMT_ONE;
            end else if (idx == pdp11_pd_pkg::IDX_MARK) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_MARK;
                r.operand_format = pdp11_pd_pkg::FMT_MARK;
            end else if (idx < pdp11_pd_pkg::IDX_GRP_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_MFPI + 7'(idx - pdp11_pd_pkg::IDX_MFPI);
                r.operand_format = pdp11_pd_pkg::FMT_ONE;
            end
        end else if (top == TOP_EIS) begin
            if (sub <= pdp11_pd_pkg::SUB_EIS_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_MUL + 7'(sub);
                r.operand_format = pdp11_pd_pkg::FMT_REGGEN;
            end else if (sub == pdp11_pd_pkg::SUB_FIS) begin
                if ((iw & pdp11_pd_pkg::FIS_ZERO_MASK) == 16'd0) begin
                    r.mnemonic_id    = pdp11_pd_pkg::ID_FADD + 7'(iw[4:3]);
                    r.operand_format = pdp11_pd_pkg::FMT_FLOAT;
                end
            end else if (sub == pdp11_pd_pkg::SUB_SOB) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_SOB;
                r.operand_format = pdp11_pd_pkg::FMT_SOB;
            end
        end else if (top == TOP_BYTE_GRP) begin
            if (idx < pdp11_pd_pkg::IDX_BR_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_BPL + 7'(idx[4:2]);
                r.operand_format = pdp11_pd_pkg::FMT_BRANCH;
            end else if (idx < pdp11_pd_pkg::IDX_EMT_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_EMT;
                r.operand_format = pdp11_pd_pkg::FMT_TRAP;
            end else if (idx < pdp11_pd_pkg::IDX_CLRB) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_TRAP;
                r.operand_format = pdp11_pd_pkg::FMT_TRAP;
            end else if (idx < pdp11_pd_pkg::IDX_GRP_END) begin
                r.mnemonic_id    = pdp11_pd_pkg::ID_CLRB + 7'(idx - pdp11_pd_pkg::IDX_CLRB);
                r.operand_format = pdp11_pd_pkg::FMT_ONE;
            end
        end

        case (r.operand_format)
            pdp11_pd_pkg::FMT_BRANCH: begin
                r.branch_target = pc + {{7{iw[7]}}, iw[7:0], 1'b0};
            end
            pdp11_pd_pkg::FMT_FLOAT: begin
                r.reg_field = iw[2:0];
            end
            pdp11_pd_pkg::FMT_TWO: begin
                r.src_spec = idx;
                r.dst_spec = low;
                take_operand(idx, fw, sw, pc, used, sval);
                take_operand(low, fw, sw, pc, used, dval);
            end
            pdp11_pd_pkg::FMT_REGGEN: begin
                r.reg_field = iw[8:6];
                r.dst_spec  = low;
                take_operand(low, fw, sw, pc, used, dval);
            end
            pdp11_pd_pkg::FMT_ONE: begin
                r.dst_spec = low;
                take_operand(low, fw, sw, pc, used, dval);
            end
            pdp11_pd_pkg::FMT_SOB: begin
                r.reg_field     = iw[8:6];
                r.branch_target = pc - {9'd0, low, 1'b0};
            end
            pdp11_pd_pkg::FMT_TRAP: begin
                r.small_immediate = iw[7:0];
            end
            pdp11_pd_pkg::FMT_MARK: begin
                r.small_immediate = {2'd0, low};
            end
            default: ;
        endcase

        r.src_value      = sval;
        r.dst_value      = dval;
        r.ext_words_used = used;
        r.next_addr      = pc;
        return r;
    endfunction

    function automatic bit field_ok(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
        if (got !== want) begin
            if (reports < REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
            reports++;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        pdp11_pd_pkg::dec_result_t want;
        bit                        good;
        if (aresetn) begin
            // The push comes first so that a result in the same cycle would still find it.
            if (s_valid && s_ready) begin
                expected_decodes.push_back(decode_window(s_inst_word, s_inst_addr,
                                                         s_ext_word_first, s_ext_word_second));
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_decodes.size() == 0) begin
                    $display("%0t: result beat with no decode pending, expected none, got id %0d",
                             $time, m_mnemonic_id);
                    fail_count++;
                end else begin
                    want = expected_decodes.pop_front();
                    good = 1'b1;
                    good &= field_ok("mnemonic_id", 16'(want.mnemonic_id),
                                     16'(m_mnemonic_id));
                    good &= field_ok("operand_format", 16'(want.operand_format),
                                     16'(m_operand_format));
                    good &= field_ok("reg_field", 16'(want.reg_field), 16'(m_reg_field));
                    good &= field_ok("src_spec", 16'(want.src_spec), 16'(m_src_spec));
                    good &= field_ok("dst_spec", 16'(want.dst_spec), 16'(m_dst_spec));
                    good &= field_ok("src_value", want.src_value, m_src_value);
                    good &= field_ok("dst_value", want.dst_value, m_dst_value);
                    good &= field_ok("branch_target", want.branch_target, m_branch_target);
                    good &= field_ok("small_immediate", 16'(want.small_immediate),
                                     16'(m_small_immediate));
                    good &= field_ok("ext_words_used", 16'(want.ext_words_used),
                                     16'(m_ext_words_used));
                    good &= field_ok("next_addr", want.next_addr, m_next_addr);
                    if (!good) begin
                        fail_count++;
                    end
                end
            end
            outstanding = expected_decodes.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the predecoder testbench: clock, reset, instruction window stimulus and verdict.
module testbench;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    // Opcode bases used to aim random words at particular groups.
    localparam logic [15:0] MISC_BASE = 16'o000000;
    localparam logic [15:0] EIS_BASE  = 16'o070000;
    localparam logic [15:0] FIS_BASE  = 16'o075000;
    localparam logic [15:0] BYTE_BASE = 16'o100000;
    localparam logic [2:0]  PC_REG    = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_inst_word;
    logic [15:0] s_inst_addr;
    logic [15:0] s_ext_word_first;
    logic [15:0] s_ext_word_second;
    logic        m_valid;
    logic        m_ready;
    logic [6:0]  m_mnemonic_id;
    logic [3:0]  m_operand_format;
    logic [2:0]  m_reg_field;
    logic [5:0]  m_src_spec;
    logic [5:0]  m_dst_spec;
    logic [15:0] m_src_value;
    logic [15:0] m_dst_value;
    logic [15:0] m_branch_target;
    logic [7:0]  m_small_immediate;
    logic [1:0]  m_ext_words_used;
    logic [15:0] m_next_addr;

    int fail_count;
    int outstanding;
    int results_checked;
    int windows_sent;

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    pdp11_instruction_predecoder dut (.*);

    pdp11_predecoder_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // At least half the operand specifiers use the PC so that immediate, absolute and relative
    // operands turn up often.
    function automatic logic [5:0] pick_spec();
        if ($urandom_range(0, 1) == 0) begin
            return {3'($urandom_range(0, 7)), PC_REG};
        end
        return 6'($urandom);
    endfunction

    function automatic logic [15:0] pick_word();
        int          grp;
        logic [3:0]  two_op;
        grp = $urandom_range(0, 10);
        case (grp)
            0, 1: return 16'($urandom);
            2: return MISC_BASE + 16'($urandom_range(0, 16'o7777));
            3: return MISC_BASE + 16'($urandom_range(0, 16'o377));
            4: return EIS_BASE + 16'($urandom_range(0, 16'o7777));
            5: return BYTE_BASE + 16'($urandom_range(0, 16'o7777));
            6, 7: begin
                two_op = 4'($urandom_range(1, 12));
                if (two_op > 4'd6) begin
                    two_op = two_op + 4'd2;
                end
                return {two_op, pick_spec(), pick_spec()};
            end
            8: return MISC_BASE + {4'd0, 6'($urandom_range(32, 55)), pick_spec()};
            9: begin
                if ($urandom_range(0, 1) == 0) begin
                    return FIS_BASE + 16'($urandom_range(0, 31));
                end
                return EIS_BASE + {4'd0, 3'($urandom_range(0, 4)), 3'($urandom), pick_spec()};
            end
            default: return BYTE_BASE + {4'd0, 6'($urandom_range(40, 55)), pick_spec()};
        endcase
    endfunction

    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            return 16'hFFF8 + 16'($urandom_range(0, 7));
        end else if (r < 3) begin
            return 16'($urandom_range(0, 7));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_ext();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 16'h0000;
        end else if (r == 1) begin
            return 16'hFFFF;
        end
        return 16'($urandom);
    endfunction

    // Offers one window and waits for its beat; valid stays high unless a gap follows.
    task automatic send_window(input logic [15:0] word, input logic [15:0] addr,
                               input logic [15:0] first_w, input logic [15:0] second_w);
        int gap;
        s_valid           <= 1'b1;
        s_inst_word       <= word;
        s_inst_addr       <= addr;
        s_ext_word_first  <= first_w;
        s_ext_word_second <= second_w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        windows_sent++;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 9) < 3) begin
            gap = gap_length();
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            send_window(pick_word(), pick_addr(), pick_ext(), pick_ext());
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
    endtask

    // Result side: random stalls, plus one long hold-off counted here when asked for.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
                stall_left = gap_length() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, quiet, outstanding);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        windows_sent = 0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b0;
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_inst_word       <= '0;
        s_inst_addr       <= '0;
        s_ext_word_first  <= '0;
        s_ext_word_second <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corner words of each group, back to back.
        send_window(16'o000000, 16'o001000, 16'h0000, 16'h0000);
        send_window(16'o000006, 16'o001002, 16'hFFFF, 16'hFFFF);
        send_window(16'o000007, 16'o001004, 16'h1234, 16'h5678);
        send_window(16'o000167, 16'hFFFC, 16'hFFFF, 16'h0000);
        send_window(16'o000207, 16'o002000, 16'h0000, 16'h0000);
        send_window(16'o000210, 16'o002002, 16'hFFFF, 16'hFFFF);
        send_window(16'o000240, 16'o002004, 16'h0000, 16'h0000);
        send_window(16'o000277, 16'o002006, 16'h0000, 16'h0000);
        send_window(16'o000377, 16'h0001, 16'hABCD, 16'h0000);
        send_window(16'o000400, 16'hFFFE, 16'h0000, 16'h0000);
        send_window(16'o000777, 16'h0000, 16'h0000, 16'h0000);
        send_window(16'o004737, 16'o003000, 16'hFFFF, 16'h0000);
        send_window(16'o006400, 16'o003002, 16'h0000, 16'h0000);
        send_window(16'o006477, 16'o003004, 16'h0000, 16'h0000);
        send_window(16'o007000, 16'o003006, 16'h0000, 16'h0000);
        send_window(16'o012727, 16'hFFFA, 16'hFFFF, 16'h0001);
        send_window(16'o016767, 16'hFFFE, 16'hFFFF, 16'hFFFF);
        send_window(16'o116161, 16'o004000, 16'h8000, 16'h7FFF);
        send_window(16'o070127, 16'o004002, 16'h0000, 16'hFFFF);
        send_window(16'o075000, 16'o004004, 16'h0000, 16'h0000);
        send_window(16'o075037, 16'o004006, 16'h0000, 16'h0000);
        send_window(16'o075040, 16'o004010, 16'h0000, 16'h0000);
        send_window(16'o076000, 16'o004012, 16'h0000, 16'h0000);
        send_window(16'o077077, 16'h0000, 16'h0000, 16'h0000);
        send_window(16'o077700, 16'o004014, 16'h0000, 16'h0000);
        send_window(16'o100377, 16'o004016, 16'h0000, 16'h0000);
        send_window(16'o104000, 16'o004020, 16'h0000, 16'h0000);
        send_window(16'o104777, 16'o004022, 16'h0000, 16'h0000);
        send_window(16'o106737, 16'o004024, 16'hFFFF, 16'h0000);
        send_window(16'o177777, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        send_random(400);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_random(500);

        // Long hold-off on the result side while windows keep coming, so the input stalls.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b1;
        send_random(24);
        wait_drained();

        tx_idle_on = 1'b1;
        send_random(400);

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        send_random(400);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d instruction windows: corner words of every group, then random words",
                 windows_sent);
        $display("aimed at each opcode group and PC operand mode; %0d results checked.",
                 results_checked);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
